FILE: rtl/cdo_pkg.sv
package cdo_pkg;

  localparam int unsigned DateW  = 11;
  localparam int unsigned OffW   = 11;
  localparam int unsigned DiffW  = 3;
  localparam int unsigned MonW   = 4;
  localparam int unsigned MdayW  = 5;
  localparam int unsigned DayW   = 12;
  localparam int unsigned WkW    = 13;
  localparam int unsigned QuoW   = 5;
  localparam int unsigned RemW   = 7;
  localparam int unsigned ProdW  = 24;

  localparam int unsigned DiffLimit  = 3;
  localparam int unsigned Recip100   = 5243;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned WeekBias   = 1029;
  localparam int unsigned DaysPerWk  = 7;
  localparam int unsigned MonPerYear = 12;

  typedef enum logic {
    ModeWeekday  = 1'b0,
    ModeMonthDay = 1'b1
  } mode_e;

  typedef enum logic {
    OpAdd  = 1'b0,
    OpDiff = 1'b1
  } op_e;

  typedef struct packed {
    logic load;
    logic decode;
    logic walk;
    logic pack;
    logic count;
  } dp_cmd_t;

  typedef struct packed {
    logic month_mode;
    logic walk_done;
    logic match;
    logic at_limit;
  } dp_stat_t;

  function automatic logic [MdayW-1:0] month_days(input logic [MonW-1:0] mo);
    logic [MdayW-1:0] d;
    case (mo) inside
      4'd2:                      d = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/cdo_datapath.sv
module cdo_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cdo_pkg::dp_cmd_t                     cmd_i,
  output cdo_pkg::dp_stat_t                    stat_o,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_mode_i,
  input  logic                                 operation_i,
  input  logic [cdo_pkg::DateW-1:0]            first_date_i,
  input  logic [cdo_pkg::DateW-1:0]            second_date_i,
  input  logic signed [cdo_pkg::OffW-1:0]      day_offset_i,
  input  logic                                 first_is_later_i,
  output logic [cdo_pkg::DateW-1:0]            result_date_o,
  output logic signed [cdo_pkg::DiffW-1:0]     day_difference_o
);

  logic                                mode_q;
  logic                                op_q;
  logic                                later_q;
  logic [cdo_pkg::DateW-1:0]           cur_q, cur_d;
  logic [cdo_pkg::DateW-1:0]           tgt_q;
  logic signed [cdo_pkg::OffW-1:0]     off_q;
  logic [cdo_pkg::DiffW-1:0]           n_q;
  logic [cdo_pkg::MonW-1:0]            mo_q, mo_d;
  logic signed [cdo_pkg::DayW-1:0]     da_q, da_d;

  logic [cdo_pkg::WkW-1:0]             wk_sum;
  logic [cdo_pkg::MdayW-1:0]           wk_fold1;
  logic [cdo_pkg::MdayW-1:0]           wk_fold2;
  logic [2:0]                          wk_res;

  logic [cdo_pkg::ProdW-1:0]           prod;
  logic [cdo_pkg::QuoW-1:0]            quo;
  logic [cdo_pkg::DateW-1:0]           rem_full;
  logic [cdo_pkg::RemW-1:0]            rem;
  logic [cdo_pkg::QuoW-1:0]            mo_wrap;
  logic [cdo_pkg::MonW-1:0]            mo_dec;
  logic signed [cdo_pkg::DayW-1:0]     da_dec;

  logic [cdo_pkg::MdayW-1:0]           days_cur;
  logic [cdo_pkg::MdayW-1:0]           days_prev;
  logic [cdo_pkg::MonW-1:0]            mo_prev;
  logic [cdo_pkg::MonW-1:0]            mo_next;
  logic signed [cdo_pkg::DayW-1:0]     days_cur_s;
  logic signed [cdo_pkg::DayW-1:0]     days_prev_s;
  logic [cdo_pkg::DateW-1:0]           packed_date;

  // weekday: bias to non-negative, fold base-8 digits (8 = 1 mod 7)
  always_comb begin
    wk_sum   = cdo_pkg::WkW'(cur_q) + cdo_pkg::WkW'(off_q)
             + cdo_pkg::WkW'(cdo_pkg::WeekBias);
    wk_fold1 = cdo_pkg::MdayW'(wk_sum[2:0]) + cdo_pkg::MdayW'(wk_sum[5:3])
             + cdo_pkg::MdayW'(wk_sum[8:6]) + cdo_pkg::MdayW'(wk_sum[11:9])
             + cdo_pkg::MdayW'(wk_sum[12]);
    wk_fold2 = cdo_pkg::MdayW'(wk_fold1[4:3]) + cdo_pkg::MdayW'(wk_fold1[2:0]);
    if (wk_fold2 >= cdo_pkg::MdayW'(cdo_pkg::DaysPerWk)) begin
      wk_res = 3'(wk_fold2 - cdo_pkg::MdayW'(cdo_pkg::DaysPerWk));
    end else begin
      wk_res = wk_fold2[2:0];
    end
  end

  // month-day: split by 100 through a reciprocal, month modulo 12
  always_comb begin
    prod     = cdo_pkg::ProdW'(cur_q) * cdo_pkg::ProdW'(cdo_pkg::Recip100);
    quo      = prod[cdo_pkg::RecipShift +: cdo_pkg::QuoW];
    rem_full = cur_q - cdo_pkg::DateW'(cdo_pkg::DateW'(quo) * cdo_pkg::DateW'(100));
    rem      = rem_full[cdo_pkg::RemW-1:0];
    if (quo >= cdo_pkg::QuoW'(cdo_pkg::MonPerYear)) begin
      mo_wrap = quo - cdo_pkg::QuoW'(cdo_pkg::MonPerYear);
    end else begin
      mo_wrap = quo;
    end
    if (mo_wrap == '0) begin
      mo_dec = cdo_pkg::MonW'(cdo_pkg::MonPerYear);
    end else begin
      mo_dec = mo_wrap[cdo_pkg::MonW-1:0];
    end
    da_dec = $signed(cdo_pkg::DayW'(rem)) + cdo_pkg::DayW'(off_q);
  end

  always_comb begin
    days_cur    = cdo_pkg::month_days(mo_q);
    mo_prev     = (mo_q == cdo_pkg::MonW'(1)) ? cdo_pkg::MonW'(cdo_pkg::MonPerYear)
                                              : mo_q - cdo_pkg::MonW'(1);
    mo_next     = (mo_q == cdo_pkg::MonW'(cdo_pkg::MonPerYear)) ? cdo_pkg::MonW'(1)
                                                                : mo_q + cdo_pkg::MonW'(1);
    days_prev   = cdo_pkg::month_days(mo_prev);
    days_cur_s  = $signed(cdo_pkg::DayW'(days_cur));
    days_prev_s = $signed(cdo_pkg::DayW'(days_prev));
    packed_date = cdo_pkg::DateW'(cdo_pkg::DateW'(mo_q) * cdo_pkg::DateW'(100))
                + cdo_pkg::DateW'(da_q[cdo_pkg::MdayW-1:0]);
  end

  always_comb begin
    cur_d = cur_q;
    mo_d  = mo_q;
    da_d  = da_q;
    if (cmd_i.decode) begin
      if (mode_q == cdo_pkg::ModeWeekday) begin
        cur_d = cdo_pkg::DateW'(wk_res);
      end else begin
        mo_d = mo_dec;
        da_d = da_dec;
      end
    end
    if (cmd_i.walk) begin
      if (da_q < $signed(cdo_pkg::DayW'(1))) begin
        mo_d = mo_prev;
        da_d = da_q + days_prev_s;
      end else begin
        mo_d = mo_next;
        da_d = da_q - days_cur_s;
      end
    end
    if (cmd_i.pack) begin
      cur_d = packed_date;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cdo_pkg::ModeMonthDay;
    end else if (cfg_we_i) begin
      mode_q <= cfg_mode_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      later_q <= first_is_later_i;
      n_q     <= '0;
      if (operation_i == cdo_pkg::OpDiff) begin
        cur_q <= first_is_later_i ? second_date_i : first_date_i;
        tgt_q <= first_is_later_i ? first_date_i : second_date_i;
        off_q <= cdo_pkg::OffW'(1);
      end else begin
        cur_q <= first_date_i;
        tgt_q <= second_date_i;
        off_q <= day_offset_i;
      end
    end else begin
      cur_q <= cur_d;
      if (cmd_i.count) begin
        n_q <= n_q + cdo_pkg::DiffW'(1);
      end
    end
    mo_q <= mo_d;
    da_q <= da_d;
  end

  assign stat_o.month_mode = (mode_q == cdo_pkg::ModeMonthDay);
  assign stat_o.walk_done  = (da_q >= $signed(cdo_pkg::DayW'(1))) && (da_q <= days_cur_s);
  assign stat_o.match      = (cur_q == tgt_q);
  assign stat_o.at_limit   = (n_q == cdo_pkg::DiffW'(cdo_pkg::DiffLimit));

  assign result_date_o    = (op_q == cdo_pkg::OpDiff) ? '0 : cur_q;
  assign day_difference_o = (op_q == cdo_pkg::OpAdd) ? '0
                          : (later_q ? $signed(n_q) : -$signed(n_q));

endmodule

FILE: rtl/cdo_ctrl.sv
module cdo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              operation_i,
  output logic              busy,
  output logic              result_valid_o,
  output cdo_pkg::dp_cmd_t  cmd_o,
  input  cdo_pkg::dp_stat_t stat_i
);

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StDecode,
    StWalk,
    StPack,
    StDone
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   valid_q;
  logic   accept;
  logic   is_diff;

  assign accept  = start && !busy_q;
  assign busy    = busy_q;
  assign result_valid_o = valid_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      StIdle, StDone: cmd_o.load = accept;
      StCheck:        cmd_o.count = !stat_i.match && !stat_i.at_limit;
      StDecode:       cmd_o.decode = 1'b1;
      StWalk:         cmd_o.walk = !stat_i.walk_done;
      StPack:         cmd_o.pack = 1'b1;
      default:        cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      is_diff <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        StIdle, StDone: begin
          if (accept) begin
            is_diff <= (operation_i == cdo_pkg::OpDiff);
            busy_q  <= 1'b1;
            state_q <= (operation_i == cdo_pkg::OpDiff) ? StCheck : StDecode;
          end else begin
            state_q <= StIdle;
          end
        end
        StCheck: begin
          if (stat_i.match || stat_i.at_limit) begin
            busy_q  <= 1'b0;
            valid_q <= 1'b1;
            state_q <= StDone;
          end else begin
            state_q <= StDecode;
          end
        end
        StDecode: begin
          if (stat_i.month_mode) begin
            state_q <= StWalk;
          end else if (is_diff) begin
            state_q <= StCheck;
          end else begin
            busy_q  <= 1'b0;
            valid_q <= 1'b1;
            state_q <= StDone;
          end
        end
        StWalk: begin
          if (stat_i.walk_done) begin
            state_q <= StPack;
          end
        end
        StPack: begin
          if (is_diff) begin
            state_q <= StCheck;
          end else begin
            busy_q  <= 1'b0;
            valid_q <= 1'b1;
            state_q <= StDone;
          end
        end
        default: begin
          busy_q  <= 1'b0;
          state_q <= StIdle;
        end
      endcase
    end
  end

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

  a_walk_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.walk |-> !stat_i.walk_done)
    else $error("month walk issued on a normalized date");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.count |-> (!stat_i.at_limit && !stat_i.match))
    else $error("difference step past limit or after match");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!busy && start))
    else $error("transaction loaded while busy");

endmodule

FILE: rtl/calendar_date_offset_add.sv
// Date offset unit on a calendar without leap years.
// Request channel: drive the request fields with start high; a transaction
// is taken at a rising edge where start is high and busy is low. One request
// is in work at a time; busy stays high until its result is out.
// Result channel: result_valid_o is high for exactly one cycle with
// result_date_o and day_difference_o; the receiver cannot hold it off, and a
// new request may be taken in that same cycle.
// Configuration channel: cfg_ready_o is always high; cfg_date_mode_i is
// written when cfg_valid_i is high. The user must write it only while no
// request is in work; the block itself does not enforce this.
// States from acceptance to the strobe cycle:
//   add, weekday mode: decode.
//   add, month-day mode: decode, month walk and pack; the walk crosses one
//   month per cycle, at most 36 for the full offset range.
//   difference: per day step (up to 3) a check, then decode (weekday) or
//   decode, walk and pack (month-day); a final check ends the work.
// The next request is taken at the edge that ends the strobe cycle.
// Reset clears the controller to idle and sets date mode to month-day.
module calendar_date_offset_add (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             operation_i,
  input  logic [cdo_pkg::DateW-1:0]        first_date_i,
  input  logic [cdo_pkg::DateW-1:0]        second_date_i,
  input  logic signed [cdo_pkg::OffW-1:0]  day_offset_i,
  input  logic                             first_is_later_i,
  output logic                             result_valid_o,
  output logic [cdo_pkg::DateW-1:0]        result_date_o,
  output logic signed [cdo_pkg::DiffW-1:0] day_difference_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_date_mode_i
);

  cdo_pkg::dp_cmd_t  cmd;
  cdo_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  cdo_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .operation_i    (operation_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd),
    .stat_i         (stat)
  );

  cdo_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_mode_i       (cfg_date_mode_i),
    .operation_i      (operation_i),
    .first_date_i     (first_date_i),
    .second_date_i    (second_date_i),
    .day_offset_i     (day_offset_i),
    .first_is_later_i (first_is_later_i),
    .result_date_o    (result_date_o),
    .day_difference_o (day_difference_o)
  );

endmodule
